>>> design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Shared codes, state encoding and the controller command bundle.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 16;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_EVENT = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  localparam logic [3:0] EV_START       = 4'd0;
  localparam logic [3:0] EV_REPSTART    = 4'd1;
  localparam logic [3:0] EV_TXADDR_ACK  = 4'd2;
  localparam logic [3:0] EV_TXDATA_ACK  = 4'd3;
  localparam logic [3:0] EV_RXDATA_ACK  = 4'd4;
  localparam logic [3:0] EV_RXADDR_ACK  = 4'd5;
  localparam logic [3:0] EV_RXDATA_NACK = 4'd6;
  localparam logic [3:0] EV_ARB_LOST    = 4'd7;
  localparam logic [3:0] EV_LAST_ERROR  = 4'd12;
  localparam logic [3:0] NO_ERROR       = 4'd13;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_FETCH = 3'b100
  } seq_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic finish;
  } seq_cmd_t;

endpackage

>>> design/i2cm_ctrl.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer controller
// Steps each accepted transfer through capture, execute and fetch phases.
// ----------------------------------------------------------------------------
module i2cm_ctrl import i2cm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output seq_cmd_t cmd
);

  seq_state_t state_r;
  seq_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign cmd.capture = start && (state_r == ST_IDLE);
  assign cmd.exec    = (state_r == ST_EXEC);
  assign cmd.finish  = (state_r == ST_FETCH);

endmodule

>>> design/i2cm_dpath.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer datapath
// Holds the message store, byte pointer, size and status, and forms results.
// ----------------------------------------------------------------------------
module i2cm_dpath import i2cm_pkg::*; #(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  seq_cmd_t   cmd,
  input  logic [1:0] in_action,
  input  logic [3:0] in_index,
  input  logic [7:0] in_data_byte,
  input  logic [4:0] in_msg_size,
  input  logic       in_set_size,
  input  logic [3:0] in_event_code,
  output logic       out_valid,
  output logic [7:0] out_send_byte,
  output logic       out_load_send,
  output logic       out_ack_enable,
  output logic       out_send_start,
  output logic       out_send_stop,
  output logic       out_continue_bus,
  output logic       out_busy_res,
  output logic       out_transfer_ok,
  output logic [3:0] out_error_code,
  output logic [7:0] out_read_byte
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int PW = $clog2(BUFFER_DEPTH + 1);
  localparam int CW = (PW > 5) ? PW : 5;
  localparam logic [PW-1:0] DEPTH_P = PW'(BUFFER_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

  typedef struct packed {
    logic lsend;
    logic ack;
    logic sstart;
    logic sstop;
    logic cont;
    logic rsel;
  } res_flags_t;

  // Captured transfer.
  action_t       act_r;
  logic [3:0]    idx_r;
  logic [7:0]    data_r;
  logic [4:0]    msize_r;
  logic          setsz_r;
  logic [3:0]    ev_r;

  // Sequencer state.
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [PW-1:0] size_r, size_nxt;
  logic          ok_r, ok_nxt;
  logic          active_r, active_nxt;
  logic [3:0]    err_r, err_nxt;
  logic          rdbit_r, rdbit_nxt;

  res_flags_t    flags_r, flags_nxt;

  logic [7:0]    store_mem [BUFFER_DEPTH];
  logic [7:0]    rd_data_r;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;

  logic [PW-1:0] evp;
  logic [PW-1:0] ptr_adv;
  logic [PW:0]   ack_sum;
  logic [CW-1:0] idx1;
  logic [CW-1:0] msz;

  logic          out_valid_r;
  logic [7:0]    out_send_byte_r;
  logic [7:0]    out_read_byte_r;
  res_flags_t    out_flags_r;
  logic          out_busy_r;
  logic          out_ok_r;
  logic [3:0]    out_err_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r   <= action_t'(in_action);
      idx_r   <= in_index;
      data_r  <= in_data_byte;
      msize_r <= in_msg_size;
      setsz_r <= in_set_size;
      ev_r    <= in_event_code;
    end
  end

  always_comb begin
    ptr_nxt    = ptr_r;
    size_nxt   = size_r;
    ok_nxt     = ok_r;
    active_nxt = active_r;
    err_nxt    = err_r;
    rdbit_nxt  = rdbit_r;
    flags_nxt  = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    evp        = '0;
    ptr_adv    = ptr_r;
    ack_sum    = '0;
    idx1       = CW'(idx_r) + CW'(1);
    msz        = CW'(msize_r);
    if (cmd.exec) begin
      unique case (act_r)
        ACT_LOAD: begin
          if ((CW'(idx_r) < DEPTH_C) && ((idx_r == 4'd0) || !rdbit_r)) begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_r);
            if (idx_r == 4'd0) rdbit_nxt = data_r[0];
          end
        end
        ACT_START: begin
          if (setsz_r) size_nxt = (msz > DEPTH_C) ? DEPTH_P : PW'(msz);
          ok_nxt           = 1'b0;
          err_nxt          = NO_ERROR;
          active_nxt       = 1'b1;
          flags_nxt.sstart = 1'b1;
          flags_nxt.cont   = 1'b1;
        end
        ACT_EVENT: begin
          if (active_r) begin
            flags_nxt.cont = 1'b1;
            unique case (ev_r)
              EV_START, EV_REPSTART, EV_TXADDR_ACK, EV_TXDATA_ACK: begin
                evp = ((ev_r == EV_START) || (ev_r == EV_REPSTART)) ? '0 : ptr_r;
                ptr_nxt = evp;
                if (evp < size_r) begin
                  rd_en           = 1'b1;
                  rd_addr         = AW'(evp);
                  flags_nxt.lsend = 1'b1;
                  if (evp < DEPTH_P) ptr_nxt = evp + PW'(1);
                end else begin
                  ok_nxt          = 1'b1;
                  active_nxt      = 1'b0;
                  flags_nxt.sstop = 1'b1;
                end
              end
              EV_RXDATA_ACK: begin
                if (ptr_r < DEPTH_P) begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(ptr_r);
                  ptr_adv = ptr_r + PW'(1);
                end
                ptr_nxt       = ptr_adv;
                ack_sum       = {1'b0, ptr_adv} + (PW+1)'(1);
                flags_nxt.ack = (ack_sum < {1'b0, size_r});
              end
              EV_RXADDR_ACK: begin
                ack_sum       = {1'b0, ptr_r} + (PW+1)'(1);
                flags_nxt.ack = (ack_sum < {1'b0, size_r});
              end
              EV_RXDATA_NACK: begin
                if (ptr_r < DEPTH_P) begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(ptr_r);
                end
                ok_nxt          = 1'b1;
                active_nxt      = 1'b0;
                flags_nxt.sstop = 1'b1;
              end
              EV_ARB_LOST: begin
                flags_nxt.sstart = 1'b1;
              end
              default: begin
                err_nxt         = (ev_r > EV_LAST_ERROR) ? EV_LAST_ERROR : ev_r;
                active_nxt      = 1'b0;
                flags_nxt.sstop = 1'b1;
              end
            endcase
          end
        end
        ACT_READ: begin
          if (ok_r && (idx1 < DEPTH_C)) begin
            rd_en          = 1'b1;
            rd_addr        = AW'(idx1);
            flags_nxt.rsel = 1'b1;
          end
        end
        default: begin
          flags_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      size_r   <= '0;
      ok_r     <= 1'b0;
      active_r <= 1'b0;
      err_r    <= NO_ERROR;
      rdbit_r  <= 1'b0;
    end else begin
      ptr_r    <= ptr_nxt;
      size_r   <= size_nxt;
      ok_r     <= ok_nxt;
      active_r <= active_nxt;
      err_r    <= err_nxt;
      rdbit_r  <= rdbit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) flags_r <= flags_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) store_mem[wr_addr] <= data_r;
    if (rd_en) rd_data_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_send_byte_r <= flags_r.lsend ? rd_data_r : 8'h00;
      out_read_byte_r <= flags_r.rsel ? rd_data_r : 8'h00;
      out_flags_r     <= flags_r;
      out_busy_r      <= active_r;
      out_ok_r        <= ok_r;
      out_err_r       <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_send_byte    = out_send_byte_r;
  assign out_load_send    = out_flags_r.lsend;
  assign out_ack_enable   = out_flags_r.ack;
  assign out_send_start   = out_flags_r.sstart;
  assign out_send_stop    = out_flags_r.sstop;
  assign out_continue_bus = out_flags_r.cont;
  assign out_busy_res     = out_busy_r;
  assign out_transfer_ok  = out_ok_r;
  assign out_error_code   = out_err_r;
  assign out_read_byte    = out_read_byte_r;

endmodule

>>> design/i2c_master_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Each transfer is accepted when start is high and busy is low. Its result
// appears on the out_ ports, marked by out_valid for one cycle, once the
// controller has stepped through its execute and fetch phases around the
// single-port message store, whose read data is registered before it reaches
// the result register. Busy is high through those phases, so a new transfer
// is not taken while one is in flight. A new transfer may be accepted in the
// cycle its predecessor's result is shown.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer import i2cm_pkg::*; #(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_action,
  input  logic [3:0] in_index,
  input  logic [7:0] in_data_byte,
  input  logic [4:0] in_msg_size,
  input  logic       in_set_size,
  input  logic [3:0] in_event_code,
  output logic       out_valid,
  output logic [7:0] out_send_byte,
  output logic       out_load_send,
  output logic       out_ack_enable,
  output logic       out_send_start,
  output logic       out_send_stop,
  output logic       out_continue_bus,
  output logic       out_busy_res,
  output logic       out_transfer_ok,
  output logic [3:0] out_error_code,
  output logic [7:0] out_read_byte
);

  seq_cmd_t cmd;

  i2cm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  i2cm_dpath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_action        (in_action),
    .in_index         (in_index),
    .in_data_byte     (in_data_byte),
    .in_msg_size      (in_msg_size),
    .in_set_size      (in_set_size),
    .in_event_code    (in_event_code),
    .out_valid        (out_valid),
    .out_send_byte    (out_send_byte),
    .out_load_send    (out_load_send),
    .out_ack_enable   (out_ack_enable),
    .out_send_start   (out_send_start),
    .out_send_stop    (out_send_stop),
    .out_continue_bus (out_continue_bus),
    .out_busy_res     (out_busy_res),
    .out_transfer_ok  (out_transfer_ok),
    .out_error_code   (out_error_code),
    .out_read_byte    (out_read_byte)
  );

endmodule

>>> design/i2cm_checker.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer checker
// Port-level checks on transfer timing and result consistency.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [7:0] out_send_byte,
  input logic       out_load_send,
  input logic       out_send_start,
  input logic       out_send_stop,
  input logic       out_continue_bus,
  input logic       out_busy_res
);

  // Every accepted transfer yields a result, marked by out_valid.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted transfer produced no result on time");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted transfer");

  a_send_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_load_send) |-> (out_send_byte == 8'h00))
    else $error("send byte nonzero without a send");

  a_start_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send_start) |-> out_continue_bus)
    else $error("start condition without releasing the bus");

  a_stop_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send_stop) |-> (!out_busy_res && out_continue_bus))
    else $error("stop condition left the transfer active");

endmodule

bind i2c_master_transfer_sequencer i2cm_checker u_i2cm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_send_byte    (out_send_byte),
  .out_load_send    (out_load_send),
  .out_send_start   (out_send_start),
  .out_send_stop    (out_send_stop),
  .out_continue_bus (out_continue_bus),
  .out_busy_res     (out_busy_res)
);
